// File: src/bfknn_pkg.sv
// Shared constants, types and codes for the k-nearest-neighbor search core.
`timescale 1ns / 1ps

package bfknn_pkg;

   // Sizing
   localparam int MAX_NEIGHBORS = 32;
   localparam int MAX_DIM       = 128;
   localparam int INDEX_BITS    = 20;

   // Fixed field widths
   localparam int COORD_W = 16;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int DIST_W  = 48;
   localparam int K_W     = 6;
   localparam int LEN_W   = 8;

   // Derived widths
   localparam int POS_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int LENE_W = $clog2(MAX_DIM + 1);
   localparam int FILL_W = $clog2(MAX_NEIGHBORS + 1);

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = LEN_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEIGHBOR_COUNT = 1'b0,
      CSR_VECTOR_LENGTH  = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_QUERY = 1'b0,
      KIND_POINT = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_INSERT,
      ST_EMIT
   } state_type;

   // Control broadcast to every cell of the sorted list
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

endpackage

// File: src/bfknn_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bfknn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: src/bfknn_cell.sv
// One entry of the sorted nearest-neighbor list: compare, shift in, shift out.
`timescale 1ns / 1ps

module bfknn_cell
   import bfknn_pkg::*;
(
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic                  entry_valid,
   input  logic [DIST_W-1:0]     new_dist,
   input  logic [INDEX_BITS-1:0] new_index,
   input  logic                  prev_lt,
   input  logic [DIST_W-1:0]     prev_dist,
   input  logic [INDEX_BITS-1:0] prev_index,
   input  logic [DIST_W-1:0]     next_dist,
   input  logic [INDEX_BITS-1:0] next_index,
   output logic [DIST_W-1:0]     entry_dist,
   output logic [INDEX_BITS-1:0] index,
   output logic                  lt
);

   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [INDEX_BITS-1:0] index_ff, index_in;

   // Strictly closer than this entry; an empty entry loses to anything
   assign lt = !entry_valid || (new_dist < dist_ff);

   always_comb begin
      dist_in  = dist_ff;
      index_in = index_ff;
      if (ctrl.insert) begin
         if (prev_lt) begin
            dist_in  = prev_dist;
            index_in = prev_index;
         end else if (lt) begin
            dist_in  = new_dist;
            index_in = new_index;
         end
      end else if (ctrl.drain) begin
         dist_in  = next_dist;
         index_in = next_index;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff  <= dist_in;
      index_ff <= index_in;
   end

   assign entry_dist = dist_ff;
   assign index      = index_ff;

endmodule

// File: src/brute_force_knn_top_k_core.sv
// Top level of the brute-force k-nearest-neighbor search core.
`timescale 1ns / 1ps
//
//   Channel   Ports                                          Handshake
//   -------   --------------------------------------------   ---------------------------
//   request   req_kind, req_coordinate, req_end_of_set       transfer on start && !busy
//   response  rsp_neighbor_index, rsp_neighbor_distance,     one neighbor per rsp_strobe,
//             rsp_last_neighbor                              no back-pressure
//   config    csr_index, csr_write_data                      transfer on csr_write_enable
//
// Steps: a query coordinate is stored as it transfers. A dataset coordinate goes through
// a query-store read, subtract and square, and saturating accumulate; the last coordinate
// of a point adds insertion into the sorted cell chain, and end_of_set adds one
// emission per neighbor while the chain shifts toward cell 0.
// Reset: synchronous; the query store is not cleared and needs no sweep.
// Stalls: busy is high from a dataset transfer until its work is done; the
// receiver cannot stall, so each result is shown for exactly one cycle.

module brute_force_knn_top_k_core
   import bfknn_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_kind,
   input  logic signed [COORD_W-1:0]   req_coordinate,
   input  logic                        req_end_of_set,
   // response channel
   output logic                        rsp_strobe,
   output logic [INDEX_BITS-1:0]       rsp_neighbor_index,
   output logic [DIST_W-1:0]           rsp_neighbor_distance,
   output logic                        rsp_last_neighbor,
   // configuration port
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_write_data
);

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [DIST_W-1:0]     acc_ff, acc_in;
   logic [INDEX_BITS-1:0] point_ff, point_in;
   logic [FILL_W-1:0]     filled_ff, filled_in;
   logic [FILL_W-1:0]     emit_cnt_ff, emit_cnt_in;
   logic [COORD_W-1:0]    coord_ff, coord_in;
   logic                  eos_ff, eos_in;
   logic                  finish_ff, finish_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;
   logic                  rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------------------
   // Handshake and effective configuration
   // ---------------------------------------------------------------------------
   logic accept;
   logic q_write;
   logic p_read;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign q_write = accept && (req_kind == KIND_QUERY);
   assign p_read  = accept && (req_kind == KIND_POINT);

   // Clamp k to 1..MAX_NEIGHBORS and the vector length to 1..MAX_DIM
   logic [FILL_W-1:0] k_eff;
   logic [LENE_W-1:0] len_eff;
   logic [FILL_W-1:0] n_eff;

   always_comb begin
      if (k_ff == '0) begin
         k_eff = FILL_W'(1);
      end else if (32'(k_ff) > MAX_NEIGHBORS) begin
         k_eff = FILL_W'(MAX_NEIGHBORS);
      end else begin
         k_eff = FILL_W'(k_ff);
      end

      if (len_ff == '0) begin
         len_eff = LENE_W'(1);
      end else if (32'(len_ff) > MAX_DIM) begin
         len_eff = LENE_W'(MAX_DIM);
      end else begin
         len_eff = LENE_W'(len_ff);
      end

      n_eff = (filled_ff < k_eff) ? filled_ff : k_eff;
   end

   // Coordinate position: fall back to 0 if the length shrank underneath it
   logic [POS_W-1:0]  pos_eff;
   logic [LENE_W-1:0] pos_inc;
   logic              pos_wrap;
   logic [POS_W-1:0]  pos_adv;

   assign pos_eff  = (LENE_W'(pos_ff) < len_eff) ? pos_ff : '0;
   assign pos_inc  = LENE_W'(pos_eff) + LENE_W'(1);
   assign pos_wrap = (pos_inc >= len_eff);
   assign pos_adv  = pos_wrap ? '0 : pos_inc[POS_W-1:0];

   // ---------------------------------------------------------------------------
   // Query store
   // ---------------------------------------------------------------------------
   logic [COORD_W-1:0] q_data;

   bfknn_ram #(
      .WIDTH (COORD_W),
      .DEPTH (MAX_DIM)
   ) u_query_ram (
      .clock   (clock),
      .wr_en   (q_write),
      .wr_addr (pos_eff),
      .wr_data (req_coordinate),
      .rd_en   (p_read),
      .rd_addr (pos_eff),
      .rd_data (q_data)
   );

   // ---------------------------------------------------------------------------
   // Distance datapath
   // ---------------------------------------------------------------------------
   logic signed [COORD_W:0] diff;
   logic [COORD_W:0]        diff_neg;
   logic [COORD_W-1:0]      mag;
   logic [DIST_W:0]         acc_sum;

   assign diff     = $signed({coord_ff[COORD_W-1], coord_ff})
                   - $signed({q_data[COORD_W-1], q_data});
   assign diff_neg = -diff;
   assign mag      = diff[COORD_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];
   assign acc_sum  = {1'b0, acc_ff} + (DIST_W + 1)'(sq_ff);

   // ---------------------------------------------------------------------------
   // Sorted cell chain: cell 0 holds the nearest entry
   // ---------------------------------------------------------------------------
   cell_ctrl_type         cell_ctrl;
   logic [DIST_W-1:0]     cell_dist  [MAX_NEIGHBORS];
   logic [INDEX_BITS-1:0] cell_index [MAX_NEIGHBORS];
   logic                  cell_lt    [MAX_NEIGHBORS];

   for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
      logic                  prev_lt;
      logic [DIST_W-1:0]     prev_dist, next_dist;
      logic [INDEX_BITS-1:0] prev_index, next_index;
      logic                  entry_valid;

      // An entry counts only below min(filled, k)
      assign entry_valid = (FILL_W'(i) < n_eff);

      if (i == 0) begin : g_head
         assign prev_lt    = 1'b0;
         assign prev_dist  = acc_ff;
         assign prev_index = point_ff;
      end else begin : g_body
         assign prev_lt    = cell_lt[i-1];
         assign prev_dist  = cell_dist[i-1];
         assign prev_index = cell_index[i-1];
      end

      if (i == MAX_NEIGHBORS - 1) begin : g_tail
         assign next_dist  = cell_dist[i];
         assign next_index = cell_index[i];
      end else begin : g_link
         assign next_dist  = cell_dist[i+1];
         assign next_index = cell_index[i+1];
      end

      bfknn_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .entry_valid (entry_valid),
         .new_dist    (acc_ff),
         .new_index   (point_ff),
         .prev_lt     (prev_lt),
         .prev_dist   (prev_dist),
         .prev_index  (prev_index),
         .next_dist   (next_dist),
         .next_index  (next_index),
         .entry_dist  (cell_dist[i]),
         .index       (cell_index[i]),
         .lt          (cell_lt[i])
      );
   end

   logic emit_last;
   assign emit_last = (FILL_W'(emit_cnt_ff + FILL_W'(1)) == n_eff);

   // ---------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (p_read) state_in = ST_SQUARE;
         ST_SQUARE: state_in = ST_ACCUM;
         ST_ACCUM:  state_in = finish_ff ? ST_INSERT : ST_IDLE;
         ST_INSERT: state_in = eos_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT:   if (emit_last) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Outputs and register updates
   // ---------------------------------------------------------------------------
   always_comb begin
      k_in          = k_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      point_in      = point_ff;
      filled_in     = filled_ff;
      emit_cnt_in   = emit_cnt_ff;
      coord_in      = coord_ff;
      eos_in        = eos_ff;
      finish_in     = finish_ff;
      sq_in         = sq_ff;
      rsp_strobe_in = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_last_in   = rsp_last_ff;
      cell_ctrl     = '0;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NEIGHBOR_COUNT: k_in   = csr_write_data[K_W-1:0];
            CSR_VECTOR_LENGTH:  len_in = csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_write) begin
               // Query coordinate: store, advance, start a new search
               pos_in    = pos_adv;
               acc_in    = '0;
               point_in  = '0;
               filled_in = '0;
            end else if (p_read) begin
               coord_in  = req_coordinate;
               eos_in    = req_end_of_set;
               finish_in = pos_wrap || req_end_of_set;
               pos_in    = (pos_wrap || req_end_of_set) ? '0 : pos_adv;
            end
         end
         ST_SQUARE: begin
            sq_in = SQ_W'(mag) * SQ_W'(mag);
         end
         ST_ACCUM: begin
            acc_in = acc_sum[DIST_W] ? '1 : acc_sum[DIST_W-1:0];
         end
         ST_INSERT: begin
            cell_ctrl.insert = 1'b1;
            filled_in        = (n_eff < k_eff) ? FILL_W'(n_eff + FILL_W'(1)) : n_eff;
            acc_in           = '0;
            point_in         = (point_ff == '1) ? point_ff : point_ff + INDEX_BITS'(1);
            emit_cnt_in      = '0;
         end
         ST_EMIT: begin
            // Hand cell 0 out and shift the chain toward the head
            cell_ctrl.drain = 1'b1;
            rsp_strobe_in   = 1'b1;
            rsp_index_in    = cell_index[0];
            rsp_dist_in     = cell_dist[0];
            rsp_last_in     = emit_last;
            emit_cnt_in     = FILL_W'(emit_cnt_ff + FILL_W'(1));
            if (emit_last) begin
               pos_in    = '0;
               acc_in    = '0;
               point_in  = '0;
               filled_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         k_ff          <= K_W'(20);
         len_ff        <= LEN_W'(100);
         pos_ff        <= '0;
         acc_ff        <= '0;
         point_ff      <= '0;
         filled_ff     <= '0;
         emit_cnt_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         len_ff        <= len_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         point_ff      <= point_in;
         filled_ff     <= filled_in;
         emit_cnt_ff   <= emit_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      coord_ff     <= coord_in;
      eos_ff       <= eos_in;
      finish_ff    <= finish_in;
      sq_ff        <= sq_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_neighbor_index    = rsp_index_ff;
   assign rsp_neighbor_distance = rsp_dist_ff;
   assign rsp_last_neighbor     = rsp_last_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff) == ST_EMIT)
      else $error("result strobe without emission cycle");

   a_insert_after_accum: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |-> $past(state_ff) == ST_ACCUM)
      else $error("insertion not preceded by accumulation");

   a_emit_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> emit_cnt_ff < n_eff)
      else $error("emission count beyond filled list");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_last_ff |=> !rsp_strobe_ff)
      else $error("result after last neighbor");

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      32'(filled_ff) <= MAX_NEIGHBORS)
      else $error("fill count beyond list size");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the brute-force k-nearest-neighbor search core.
`timescale 1ns / 1ps

module tb_top;
   import bfknn_pkg::*;

   // One coordinate transfer on the request channel
   typedef struct {
      kind_type                   kind;
      logic signed [COORD_W-1:0]  coord;
      logic                       eos;
   } coord_item_t;

   // One neighbor on the response channel
   typedef struct {
      logic [INDEX_BITS-1:0]  index;
      logic [DIST_W-1:0]      distance;
      logic                   last;
   } neighbor_t;

   localparam int              RANDOM_ITEMS = 210;
   localparam int              QUIET_CYCLES = 48;   // longest emission plus pipeline slack
   localparam int              CYCLE_LIMIT  = 200000;
   localparam int              PHASE_ITEMS  = 60;   // cap on coordinates per random search
   localparam longint unsigned DIST_LIMIT   = (64'd1 << DIST_W) - 64'd1;
   localparam int unsigned     INDEX_LIMIT  = (32'd1 << INDEX_BITS) - 32'd1;

   // DUT ports; every input holds a known value from time zero
   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_kind = 1'b0;
   logic signed [COORD_W-1:0]  req_coordinate = '0;
   logic                       req_end_of_set = 1'b0;
   logic                       rsp_strobe;
   logic [INDEX_BITS-1:0]      rsp_neighbor_index;
   logic [DIST_W-1:0]          rsp_neighbor_distance;
   logic                       rsp_last_neighbor;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data = '0;

   brute_force_knn_top_k_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_kind              (req_kind),
      .req_coordinate        (req_coordinate),
      .req_end_of_set        (req_end_of_set),
      .rsp_strobe            (rsp_strobe),
      .rsp_neighbor_index    (rsp_neighbor_index),
      .rsp_neighbor_distance (rsp_neighbor_distance),
      .rsp_last_neighbor     (rsp_last_neighbor),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // Clock: 20 ns period
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Search predictor: own copy of registers, query vector and sorted list
   // ---------------------------------------------------------------------------
   logic [K_W-1:0]             knn_k_reg   = 6'd20;
   logic [LEN_W-1:0]           knn_len_reg = 8'd100;
   logic signed [COORD_W-1:0]  query_vec [MAX_DIM];
   int unsigned                coord_pos    = 0;
   longint unsigned            partial_dist = 0;
   int unsigned                point_number = 0;
   longint unsigned            best_dist  [MAX_NEIGHBORS];
   logic [INDEX_BITS-1:0]      best_index [MAX_NEIGHBORS];
   int unsigned                best_filled = 0;

   neighbor_t                  neighbors_due [$];   // neighbors predicted, not yet seen

   int                         mismatches     = 0;
   int                         searches_done  = 0;
   int                         coords_sent    = 0;
   int                         neighbors_seen = 0;
   int                         cycle_count    = 0;

   // Clamp the registers the way the core uses them
   function automatic int unsigned active_k();
      if (knn_k_reg == 0) return 1;
      if (knn_k_reg > MAX_NEIGHBORS) return MAX_NEIGHBORS;
      return knn_k_reg;
   endfunction

   function automatic int unsigned active_len();
      if (knn_len_reg == 0) return 1;
      if (knn_len_reg > MAX_DIM) return MAX_DIM;
      return knn_len_reg;
   endfunction

   // Insert a finished point; strictly closer replaces the worst, ties keep the older
   function automatic void rank_point(longint unsigned pt_dist, logic [INDEX_BITS-1:0] idx);
      int unsigned     k_now;
      int unsigned     n;
      int unsigned     j;
      longint unsigned swap_dist;
      logic [INDEX_BITS-1:0] swap_index;
      k_now = active_k();
      n = (best_filled < k_now) ? best_filled : k_now;
      if (n < k_now) begin
         best_dist[n]  = pt_dist;
         best_index[n] = idx;
         n++;
      end else if (pt_dist < best_dist[n-1]) begin
         best_dist[n-1]  = pt_dist;
         best_index[n-1] = idx;
      end else begin
         best_filled = n;
         return;
      end
      best_filled = n;
      j = n - 1;
      // bubble the new entry toward the nearest end
      while (j >= 1 && best_dist[j] < best_dist[j-1]) begin
         swap_dist       = best_dist[j];
         swap_index      = best_index[j];
         best_dist[j]    = best_dist[j-1];
         best_index[j]   = best_index[j-1];
         best_dist[j-1]  = swap_dist;
         best_index[j-1] = swap_index;
         j--;
      end
   endfunction

   function automatic void restart_search();
      partial_dist = 0;
      point_number = 0;
      best_filled  = 0;
   endfunction

   // Advance the predictor by one accepted coordinate; queue any neighbors it emits
   function automatic void search_step(coord_item_t it);
      int unsigned     len_now;
      int unsigned     p;
      int unsigned     n;
      longint          diff;
      longint unsigned mag;
      longint unsigned sq;
      neighbor_t       nb;
      len_now = active_len();
      p = (coord_pos < len_now) ? coord_pos : 0;
      if (it.kind == KIND_QUERY) begin
         // a query coordinate always opens a new search; end_of_set means nothing here
         query_vec[p] = it.coord;
         p++;
         coord_pos = (p >= len_now) ? 0 : p;
         restart_search();
         return;
      end
      diff = longint'(it.coord) - longint'(query_vec[p]);
      mag  = (diff < 0) ? -diff : diff;
      sq   = mag * mag;
      if (sq > DIST_LIMIT - partial_dist) partial_dist = DIST_LIMIT;
      else partial_dist += sq;
      p++;
      // an early end_of_set closes the point with whatever distance it has
      if (p >= len_now || it.eos) begin
         rank_point(partial_dist, point_number[INDEX_BITS-1:0]);
         if (point_number < INDEX_LIMIT) point_number++;
         partial_dist = 0;
         p = 0;
      end
      coord_pos = p;
      if (!it.eos) return;
      n = (best_filled < active_k()) ? best_filled : active_k();
      for (int i = 0; i < n; i++) begin
         nb.index    = best_index[i];
         nb.distance = best_dist[i][DIST_W-1:0];
         nb.last     = (i + 1 == n);
         neighbors_due.insert(neighbors_due.size(), nb);
      end
      coord_pos = 0;
      restart_search();
      searches_done++;
   endfunction

   // ---------------------------------------------------------------------------
   // Mismatch reporting: one line each, the first few only, all counted
   // ---------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      if (mismatches < 30) $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------
   // Driver: present queued coordinates, transfer on start && !busy
   // ---------------------------------------------------------------------------
   coord_item_t coords_to_send [$];
   coord_item_t coord_on_bus;
   int          sender_gap = 0;
   bit          gapless    = 1'b0;   // set for a phase to stream back to back

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         sender_gap = 0;
      end else begin
         // a transfer completes at this edge: feed it to the predictor
         if (start && !busy) begin
            search_step(coord_on_bus);
            coords_sent++;
         end
         // the slot is free once nothing is offered or the offer was just taken
         if (!start || !busy) begin
            if (sender_gap > 0) begin
               sender_gap--;
               start <= 1'b0;
            end else if (coords_to_send.size() != 0) begin
               coord_on_bus = coords_to_send.pop_front();
               req_kind       <= coord_on_bus.kind;
               req_coordinate <= coord_on_bus.coord;
               req_end_of_set <= coord_on_bus.eos;
               start          <= 1'b1;
               sender_gap = gapless ? 0 : int'($urandom_range(0, 6));
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: each strobe is one neighbor; compare against the oldest prediction
   // ---------------------------------------------------------------------------
   neighbor_t neighbor_want;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         neighbors_seen++;
         if (neighbors_due.size() == 0) begin
            report_mismatch($sformatf("unexpected neighbor index %0d distance %0d",
                                      rsp_neighbor_index, rsp_neighbor_distance));
         end else begin
            neighbor_want = neighbors_due.pop_front();
            if (rsp_neighbor_index !== neighbor_want.index)
               report_mismatch($sformatf("neighbor_index %0d, want %0d",
                                         rsp_neighbor_index, neighbor_want.index));
            if (rsp_neighbor_distance !== neighbor_want.distance)
               report_mismatch($sformatf("neighbor_distance %0d, want %0d",
                                         rsp_neighbor_distance, neighbor_want.distance));
            if (rsp_last_neighbor !== neighbor_want.last)
               report_mismatch($sformatf("last_neighbor %0b, want %0b",
                                         rsp_last_neighbor, neighbor_want.last));
         end
      end
   end

   // Watchdog: count cycles, give up far beyond the slowest correct run
   always @(posedge clock) cycle_count++;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("brute_force_knn_top_k_core test failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus generation. A shadow of the coordinate position tracks which query
   // entries hold data, so no dataset coordinate ever reads an unwritten entry.
   // ---------------------------------------------------------------------------
   bit          query_written [MAX_DIM];
   int unsigned plan_pos     = 0;
   int          items_queued = 0;

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 4))
         0: begin
            case ($urandom_range(0, 2))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               default: return 16'sh0000;
            endcase
         end
         // small values make equal distances common
         1:       return 16'($urandom_range(0, 8)) - 16'd4;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void queue_coord(kind_type kind, logic signed [COORD_W-1:0] coord,
                                       logic eos);
      coord_item_t it;
      int unsigned len_now;
      int unsigned p;
      len_now = active_len();
      p = (plan_pos < len_now) ? plan_pos : 0;
      // turn a dataset coordinate into a query write where the entry is still empty
      if (kind == KIND_POINT && !query_written[p]) kind = KIND_QUERY;
      if (kind == KIND_QUERY) begin
         query_written[p] = 1'b1;
         plan_pos = (p + 1 >= len_now) ? 0 : p + 1;
      end else begin
         plan_pos = (p + 1 >= len_now || eos) ? 0 : p + 1;
      end
      it.kind  = kind;
      it.coord = coord;
      it.eos   = eos;
      coords_to_send.insert(coords_to_send.size(), it);
      items_queued++;
   endfunction

   // Full query vector; end_of_set is set now and then since the core ignores it there
   function automatic void queue_query();
      for (int i = 0; i < active_len(); i++)
         queue_coord(KIND_QUERY, rand_coord(), $urandom_range(0, 7) == 0);
   endfunction

   function automatic void queue_point(bit closes_set);
      for (int i = 0; i < active_len(); i++)
         queue_coord(KIND_POINT, rand_coord(), closes_set && (i == active_len() - 1));
   endfunction

   // Hold until the core has gone quiet: nothing queued, offered, busy or due
   task automatic wait_quiet();
      while (coords_to_send.size() != 0 || start || busy || neighbors_due.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Write both registers while the core is idle; mirror them in the predictor
   task automatic program_search(input logic [CSR_DATA_W-1:0] k_raw,
                                 input logic [CSR_DATA_W-1:0] len_raw);
      wait_quiet();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_NEIGHBOR_COUNT;
      csr_write_data   <= k_raw;
      @(posedge clock);
      csr_index        <= CSR_VECTOR_LENGTH;
      csr_write_data   <= len_raw;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      knn_k_reg   = k_raw[K_W-1:0];
      knn_len_reg = len_raw;
      gapless     = ($urandom_range(0, 3) == 0);
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      int                    random_from;
      int unsigned           npts;
      int unsigned           cut;
      logic [CSR_DATA_W-1:0] k_raw;
      logic [CSR_DATA_W-1:0] len_raw;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // k = 2, length 2: extreme coordinates, two points at distance zero (tie keeps
      // the older one first), end_of_set on a query coordinate is ignored
      program_search(8'd2, 8'd2);
      queue_coord(KIND_QUERY, 16'sh7FFF, 1'b0);
      queue_coord(KIND_QUERY, 16'sh8000, 1'b1);
      queue_coord(KIND_POINT, 16'sh8000, 1'b0);
      queue_coord(KIND_POINT, 16'sh7FFF, 1'b0);
      queue_coord(KIND_POINT, 16'sh7FFF, 1'b0);
      queue_coord(KIND_POINT, 16'sh8000, 1'b0);
      queue_coord(KIND_POINT, 16'sh7FFF, 1'b0);
      queue_coord(KIND_POINT, 16'sh8000, 1'b0);
      queue_coord(KIND_POINT, 16'sh0000, 1'b0);
      queue_coord(KIND_POINT, 16'sh0000, 1'b1);
      // early end_of_set on the first coordinate of a point; reused query
      queue_coord(KIND_POINT, 16'sh0005, 1'b1);
      // query coordinate dropped into the middle of a point restarts the search
      queue_coord(KIND_POINT, 16'sh0064, 1'b0);
      queue_coord(KIND_QUERY, 16'sh8000, 1'b0);
      queue_coord(KIND_POINT, 16'sh0001, 1'b0);
      queue_coord(KIND_POINT, 16'shFFFF, 1'b1);

      // upper data bits of k are dropped; fewer points than k, with a tie
      program_search(8'hC5, 8'd1);
      queue_coord(KIND_QUERY, 16'shFFFF, 1'b0);
      queue_coord(KIND_POINT, 16'sh0000, 1'b0);
      queue_coord(KIND_POINT, 16'shFFFE, 1'b0);
      queue_coord(KIND_POINT, 16'shFFFF, 1'b1);

      // zero in both registers clamps to one neighbor, one coordinate
      program_search(8'h00, 8'h00);
      queue_coord(KIND_QUERY, 16'sh1234, 1'b0);
      queue_coord(KIND_POINT, 16'sh0000, 1'b0);
      queue_coord(KIND_POINT, 16'sh7FFF, 1'b0);
      queue_coord(KIND_POINT, 16'sh8000, 1'b1);

      // random part: first a full list of 32 with plenty of replacements
      random_from = items_queued;
      program_search(8'h20, 8'd1);
      queue_query();
      for (int i = 0; i < 40; i++) queue_point(i == 39);

      while (items_queued - random_from < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0: begin
               case ($urandom_range(0, 3))
                  0:       k_raw[K_W-1:0] = 6'd0;
                  1:       k_raw[K_W-1:0] = 6'd1;
                  2:       k_raw[K_W-1:0] = 6'd32;
                  default: k_raw[K_W-1:0] = 6'd63;
               endcase
            end
            default: k_raw[K_W-1:0] = K_W'($urandom_range(0, 40));
         endcase
         k_raw[CSR_DATA_W-1:K_W] = (CSR_DATA_W - K_W)'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0:       len_raw = 8'd0;
            1:       len_raw = 8'd1;
            2:       len_raw = CSR_DATA_W'($urandom_range(9, 20));
            default: len_raw = CSR_DATA_W'($urandom_range(2, 6));
         endcase
         program_search(k_raw, len_raw);

         npts = $urandom_range(1, active_k() + 4);
         if (npts * active_len() > PHASE_ITEMS) npts = PHASE_ITEMS / active_len();
         if (npts == 0) npts = 1;

         case ($urandom_range(0, 9))
            6: begin
               // lower k in the middle of a search, then finish it
               queue_query();
               for (int i = 0; i < npts; i++) queue_point(1'b0);
               k_raw[K_W-1:0] = K_W'($urandom_range(0, knn_k_reg));
               program_search(k_raw, knn_len_reg);
               for (int i = 0; i < 3; i++) queue_point(i == 2);
            end
            7: begin
               // close the set partway through a point
               queue_query();
               for (int i = 0; i < npts; i++) queue_point(1'b0);
               cut = $urandom_range(1, active_len());
               for (int i = 0; i < cut; i++)
                  queue_coord(KIND_POINT, rand_coord(), i == cut - 1);
            end
            8: begin
               // a query coordinate lands inside a point, then the search goes on
               queue_query();
               for (int i = 0; i < npts / 2; i++) queue_point(1'b0);
               queue_coord(KIND_POINT, rand_coord(), 1'b0);
               queue_coord(KIND_QUERY, rand_coord(), 1'b0);
               for (int i = 0; i <= npts / 2; i++) queue_point(i == npts / 2);
            end
            9: begin
               // noise: anything the fields allow
               repeat ($urandom_range(3, 10))
                  queue_coord(kind_type'($urandom_range(0, 1)), rand_coord(),
                              $urandom_range(0, 3) == 0);
            end
            default: begin
               queue_query();
               for (int i = 0; i < npts; i++) queue_point(i == npts - 1);
            end
         endcase
      end

      // longest vectors: 255 clamps to the full 128 coordinates, largest k; the point
      // after the query closes the set after a few coordinates
      program_search(8'hFF, 8'hFF);
      queue_query();
      for (int i = 0; i < 4; i++) queue_coord(KIND_POINT, rand_coord(), i == 3);

      wait_quiet();
      $display("covered %0d searches, %0d coordinate transfers, %0d neighbors checked",
               searches_done, coords_sent, neighbors_seen);
      $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
      if (mismatches == 0) $display("brute_force_knn_top_k_core test passed");
      else $display("brute_force_knn_top_k_core test failed");
      $finish;
   end

endmodule
